// ----- hdl/aenc_pkg.sv -----
`default_nettype none
package aenc_pkg;
	localparam int PAT_W = 33;
	localparam int CNT_W = 6;
	localparam int PEND_W = 5;
	localparam logic [PEND_W-1:0] PEND_MAX = 5'd31;

	typedef struct packed {
		logic load;     // take input item, latch the counts
		logic div_go;
		logic narrow;   // apply quotients to interval
		logic step;     // one renormalization step
		logic flush;
		logic clear;    // return interval and pending count to reset state
		logic emit_ack; // result transfer done
	} cmd_t;

	typedef struct packed {
		logic bad;      // malformed counts
		logic div_done;
		logic empty;    // empty subinterval
		logic emit;     // current step emits a bit
		logic e3;       // current step counts an underflow
		logic out_full; // result register busy
	} sts_t;
endpackage
`default_nettype wire

// ----- hdl/aenc_div.sv -----
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module aenc_div #(
	parameter int NW = 49,
	parameter int DW = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic               done,
	output logic [NW-1:0]      quo
);
	localparam int CW = $clog2(NW + 1);
	logic [NW-1:0] n_q;
	logic [DW:0]   r_q;
	logic [DW-1:0] d_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [DW:0]   trial;
	logic [DW+1:0] diff;

	assign trial = {r_q[DW-1:0], n_q[NW-1]};
	assign diff = {1'b0, trial} - {2'b00, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			d_q <= den;
			r_q <= '0;
		end else if (busy_q) begin
			if (!diff[DW+1]) begin
				r_q <= diff[DW:0];
				n_q <= {n_q[NW-2:0], 1'b1};
			end else begin
				r_q <= trial;
				n_q <= {n_q[NW-2:0], 1'b0};
			end
		end
	end
	assign quo = n_q;
endmodule
`default_nettype wire

// ----- hdl/aenc_dp.sv -----
`default_nettype none
module aenc_dp #(
	parameter int CODE_BITS = 32,
	parameter int TOTAL_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire aenc_pkg::cmd_t     cmd,
	output aenc_pkg::sts_t          sts,
	input  wire logic [15:0]        cum_low,
	input  wire logic [15:0]        cum_high,
	input  wire logic [15:0]        freq_total,
	output logic [aenc_pkg::PAT_W-1:0] out_pattern,
	output logic [aenc_pkg::CNT_W-1:0] out_count,
	output logic                    pending_overflow,
	output logic                    out_last,
	output logic                    out_valid
);
	import aenc_pkg::*;
	localparam int RW = CODE_BITS + 1;
	localparam int NW = RW + TOTAL_BITS;

	logic [CODE_BITS-1:0]  low_q, high_q;
	logic [PEND_W-1:0]     pend_q;
	logic                  sat_q;
	logic [TOTAL_BITS-1:0] cl, ch, tot;
	logic [TOTAL_BITS-1:0] cl_q, ch_q, tot_q;
	logic [RW-1:0]         range;
	logic [NW-1:0]         qh, ql;
	logic                  dh, dl, dh_q, dl_q;
	logic [PEND_W:0]       pn;
	logic [PAT_W-1:0]      fill, pat;
	logic                  b;

	assign cl = cum_low[TOTAL_BITS-1:0];
	assign ch = cum_high[TOTAL_BITS-1:0];
	assign tot = freq_total[TOTAL_BITS-1:0];
	assign range = {1'b0, high_q} - {1'b0, low_q} + RW'(1);

	aenc_div #(.NW(NW), .DW(TOTAL_BITS)) u_dh (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_go),
		.num(NW'(range) * NW'(ch_q)), .den(tot_q), .done(dh), .quo(qh));
	aenc_div #(.NW(NW), .DW(TOTAL_BITS)) u_dl (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_go),
		.num(NW'(range) * NW'(cl_q)), .den(tot_q), .done(dl), .quo(ql));

	always_comb begin
		sts.bad = (tot == '0) || (ch > tot) || (cl >= ch);
		sts.div_done = dh_q && dl_q;
		sts.empty = qh <= ql;
		sts.emit = high_q[CODE_BITS-1] == low_q[CODE_BITS-1];
		sts.e3 = low_q[CODE_BITS-2] && !high_q[CODE_BITS-2];
		sts.out_full = out_valid;
	end

	// pattern: bit b then pn copies of ~b
	always_comb begin
		if (cmd.flush) begin
			b = low_q[CODE_BITS-2];
			pn = {1'b0, pend_q} + 1'b1;
		end else begin
			b = high_q[CODE_BITS-1];
			pn = {1'b0, pend_q};
		end
		fill = (PAT_W'(1) << pn) - PAT_W'(1);
		pat = (PAT_W'(b) << pn) | (b ? '0 : fill);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q <= '0;
			high_q <= '1;
			pend_q <= '0;
			sat_q <= 1'b0;
			out_valid <= 1'b0;
			out_pattern <= '0;
			out_count <= '0;
			pending_overflow <= 1'b0;
			out_last <= 1'b0;
			dh_q <= 1'b0;
			dl_q <= 1'b0;
		end else begin
			if (cmd.div_go) begin
				dh_q <= 1'b0;
				dl_q <= 1'b0;
			end else begin
				if (dh) dh_q <= 1'b1;
				if (dl) dl_q <= 1'b1;
			end
			if (cmd.emit_ack) out_valid <= 1'b0;
			if (cmd.flush) begin
				out_pattern <= pat;
				out_count <= CNT_W'(pn) + 1'b1;
				pending_overflow <= sat_q;
				out_last <= 1'b1;
				out_valid <= 1'b1;
			end
			if (cmd.clear) begin
				low_q <= '0;
				high_q <= '1;
				pend_q <= '0;
				sat_q <= 1'b0;
			end else if (cmd.narrow) begin
				high_q <= CODE_BITS'(NW'(low_q) + qh - NW'(1));
				low_q <= CODE_BITS'(NW'(low_q) + ql);
			end else if (cmd.step) begin
				if (sts.emit) begin
					out_pattern <= pat;
					out_count <= CNT_W'(pn) + 1'b1;
					pending_overflow <= sat_q;
					out_last <= 1'b0;
					out_valid <= 1'b1;
					pend_q <= '0;
					sat_q <= 1'b0;
					low_q <= {low_q[CODE_BITS-2:0], 1'b0};
					high_q <= {high_q[CODE_BITS-2:0], 1'b1};
				end else begin
					if (pend_q != PEND_MAX) pend_q <= pend_q + 1'b1;
					else sat_q <= 1'b1;
					low_q <= {1'b0, low_q[CODE_BITS-3:0], 1'b0};
					high_q <= {1'b1, high_q[CODE_BITS-3:0], 1'b1};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cl_q <= cl;
			ch_q <= ch;
			tot_q <= tot;
		end
	end
endmodule
`default_nettype wire

// ----- hdl/aenc_ctrl.sv -----
`default_nettype none
module aenc_ctrl #(
	parameter int CODE_BITS = 32
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_xfer,
	input  wire logic           in_kind,
	input  wire logic           out_xfer,
	input  wire aenc_pkg::sts_t sts,
	output aenc_pkg::cmd_t      cmd,
	output logic                in_ready,
	output logic                mark_last
);
	import aenc_pkg::*;
	localparam logic [2:0] S_IDLE = 3'd0, S_DIV = 3'd1, S_WAIT = 3'd2,
		S_NARROW = 3'd3, S_RENORM = 3'd4, S_DRAIN = 3'd5;
	localparam int IW = $clog2(CODE_BITS + 2);

	logic [2:0]    state_q;
	logic [IW-1:0] iter_q;
	logic [5:0]    nres_q;
	logic          ok_step, more;

	// step allowed if room for result; loop bound and result cap
	assign more = (iter_q < IW'(CODE_BITS + 1)) && (sts.emit || sts.e3)
		&& !(sts.emit && nres_q >= 6'd32);
	assign ok_step = (state_q == S_RENORM) && more && !(sts.emit && sts.out_full && !out_xfer);
	assign in_ready = (state_q == S_IDLE) && !sts.out_full;

	always_comb begin
		cmd = '0;
		cmd.emit_ack = out_xfer;
		cmd.load = in_xfer && !in_kind;
		cmd.flush = in_xfer && in_kind;
		cmd.clear = in_xfer && in_kind;
		cmd.div_go = state_q == S_DIV;
		cmd.narrow = (state_q == S_NARROW) && !sts.empty;
		cmd.step = ok_step;
	end

	// last flag: set on held result once renorm stops
	assign mark_last = (state_q == S_RENORM) && !more;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			iter_q <= '0;
			nres_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (in_xfer && !in_kind) state_q <= sts.bad ? S_IDLE : S_DIV;
				S_DIV: state_q <= S_WAIT;
				S_WAIT: if (sts.div_done) state_q <= S_NARROW;
				S_NARROW: begin
					iter_q <= '0;
					nres_q <= '0;
					state_q <= sts.empty ? S_IDLE : S_RENORM;
				end
				S_RENORM: begin
					if (!more) state_q <= S_IDLE;
					else if (ok_step) begin
						iter_q <= iter_q + 1'b1;
						if (sts.emit) nres_q <= nres_q + 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- hdl/arithmetic_encoder_32bit.sv -----
`default_nettype none
// Binary arithmetic encoder with underflow handling. An encode transfer runs
// the two bit-serial divisions (in parallel), then the renormalization
// steps, each emitted bit waiting for the previous result to be taken. A
// flush transfer yields one result, registered in the cycle after it is
// taken. Results of one input are marked by tlast; each result is held
// back until the next emitting step or the end of the loop is reached, so the
// final one carries tlast.
module arithmetic_encoder_32bit #(
	parameter int CODE_BITS = 32,
	parameter int TOTAL_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,  // cum_low, cum_high, freq_total
	input  wire logic        s_tuser,  // kind
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,  // out_pattern, out_count, pending_overflow
	output logic             m_tlast
);
	import aenc_pkg::*;
	cmd_t cmd;
	sts_t sts;
	logic [PAT_W-1:0] pat;
	logic [CNT_W-1:0] cnt;
	logic ovf, lst, vld, mark, in_x, out_x, last_q, hold;

	assign in_x = s_tvalid && s_tready;
	assign out_x = m_tvalid && m_tready;

	aenc_ctrl #(.CODE_BITS(CODE_BITS)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_xfer(in_x), .in_kind(s_tuser),
		.out_xfer(out_x), .sts(sts), .cmd(cmd), .in_ready(s_tready),
		.mark_last(mark));

	aenc_dp #(.CODE_BITS(CODE_BITS), .TOTAL_BITS(TOTAL_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cum_low(s_tdata[15:0]), .cum_high(s_tdata[31:16]),
		.freq_total(s_tdata[47:32]), .out_pattern(pat), .out_count(cnt),
		.pending_overflow(ovf), .out_last(lst), .out_valid(vld));

	// a step result is shown only once it is known whether another follows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold <= 1'b0;
			last_q <= 1'b0;
		end else begin
			if (cmd.step && sts.emit) begin
				hold <= 1'b1;
				last_q <= 1'b0;
			end else if (cmd.flush) begin
				hold <= 1'b0;
			end else if (mark && vld && hold) begin
				hold <= 1'b0;
				last_q <= 1'b1;
			end else if (hold && cmd.step) begin
				hold <= 1'b1;
			end
		end
	end

	// held result goes out when the next step emits or the loop has ended
	always_comb begin
		m_tvalid = vld && !(hold && !mark && !sts.emit);
		m_tlast = lst || last_q || (hold && mark);
		m_tdata = {ovf, cnt, pat};
	end
endmodule
`default_nettype wire
